[design/lms3_pkg.sv]
// ---------------------------------------------------------------------------
// lms3_pkg - shared types and codes for the 3D linear motion stepper
// Request codes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package lms3_pkg;

    localparam logic [1:0] REQ_MOVE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_SET  = 2'd2;
    localparam logic [1:0] REQ_STOP = 2'd3;

    localparam int SPEED_W = 32;
    localparam int TICK_W  = 20;
    localparam int VEL_W   = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_TICK,
        S_TEND,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[design/linear_motion_stepper_3d_core.sv]
// ---------------------------------------------------------------------------
// linear_motion_stepper_3d_core - constant speed 3D linear motion stepper
// Move, tick, set-position and stop requests; one status result per request.
// ---------------------------------------------------------------------------
//  channel   dir  tdata                              tuser
//  s_axis    in   x, y, z, move_speed, tick_time     req_type
//  m_axis    out  cur_x, cur_y, cur_z, moving, arr   -
//
//  Move: shift-add squaring of each axis distance, a bit-serial square root,
//  then per axis a shift-add multiply and a restoring divide (skipped for zero
//  distance or zero speed), then the result. Tick: one 32x20 multiply per axis
//  while moving with no pending set. Set/stop: straight to the result.
//  s_axis_tready is high only in idle; a result waits in the output register
//  until taken. Reset zeroes control, position, target and velocity state only.
`default_nettype none

module linear_motion_stepper_3d_core
    import lms3_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // coord_x[31:0], coord_y[63:32], coord_z[95:64], move_speed[127:96],
    // tick_time[147:128], zero pad
    input  wire logic [151:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // cur_x[31:0], cur_y[63:32], cur_z[95:64], is_moving[96], arrived[97], pad
    output logic [103:0]      m_axis_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int RW    = CB + 1;
    localparam int SUM_W = 2 * CB + 2;
    localparam int ACC_W = (2 * CB + 2 > CB + SPEED_W) ? 2 * CB + 2 : CB + SPEED_W;
    localparam int MPL_W = (CB > SPEED_W) ? CB : SPEED_W;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam int PRD_W = VEL_W + TICK_W;
    localparam int S_W   = PRD_W - 16;
    localparam int CMP_W = (CB > S_W) ? CB : S_W;

    state_t state_reg, state_next;

    logic [CB-1:0]      pos_reg [3];
    logic [CB-1:0]      pos_next [3];
    logic [CB-1:0]      tgt_reg [3];
    logic [CB-1:0]      tgt_next [3];
    logic [CB-1:0]      npos_reg [3];
    logic [CB-1:0]      npos_next [3];
    logic [VEL_W-1:0]   vel_reg [3];
    logic [VEL_W-1:0]   vel_next [3];
    logic               moving_reg, moving_next;
    logic               pend_reg, pend_next;
    logic               arr_reg, arr_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [TICK_W-1:0]  t_reg, t_next;
    logic [1:0]         ax_reg, ax_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [MPL_W-1:0]   mplier_reg, mplier_next;
    logic [RW+2:0]      rem_reg, rem_next;
    logic [RW-1:0]      root_reg, root_next;
    logic               ovalid_reg, ovalid_next;
    logic [103:0]       odata_reg, odata_next;

    logic               in_xfer;
    logic               out_free;
    logic [CB-1:0]      cin [3];
    logic [CB-1:0]      d_ax;
    logic               neg_ax;
    logic [CB-1:0]      m_ax;
    logic [RW+2:0]      rem_sh, trial;
    logic [RW:0]        drem_sh;
    logic               qbit;
    logic [VEL_W-1:0]   q32, vsat;
    logic [VEL_W-1:0]   vmag;
    logic [PRD_W-1:0]   tprod;
    logic [S_W-1:0]     s_ax;
    logic [CB-1:0]      step_cb;
    logic               vel_zero;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    assign cin[0] = CB'($signed(s_axis_tdata[31:0]));
    assign cin[1] = CB'($signed(s_axis_tdata[63:32]));
    assign cin[2] = CB'($signed(s_axis_tdata[95:64]));

    // per-axis operand: remaining distance to target
    assign d_ax   = tgt_reg[ax_reg] - pos_reg[ax_reg];
    assign neg_ax = d_ax[CB-1];
    assign m_ax   = neg_ax ? (~d_ax + CB'(1)) : d_ax;

    // sqrt step: bring down two bits of the sum
    assign rem_sh = {rem_reg[RW:0], acc_reg[SUM_W-1:SUM_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // restoring divide step
    assign drem_sh = {rem_reg[RW-1:0], acc_reg[ACC_W-1]};
    assign qbit    = (drem_sh >= {1'b0, root_reg});

    // finished quotient including this cycle's bit; below 2^32, saturate to
    // signed 32 bits
    assign q32  = {acc_reg[VEL_W-2:0], qbit};
    always_comb
    begin
        if (neg_ax)
            vsat = (q32 > 32'h8000_0000) ? 32'h8000_0000 : (~q32 + 32'd1);
        else
            vsat = q32[VEL_W-1] ? 32'h7FFF_FFFF : q32;
    end

    assign vmag    = vel_reg[ax_reg][VEL_W-1] ? (~vel_reg[ax_reg] + 32'd1) : vel_reg[ax_reg];
    assign tprod   = PRD_W'(vmag) * PRD_W'(t_reg);
    assign s_ax    = tprod[PRD_W-1:16];
    assign step_cb = vel_reg[ax_reg][VEL_W-1] ? (~CB'(s_ax) + CB'(1)) : CB'(s_ax);
    assign vel_zero = (vel_reg[0] == '0) && (vel_reg[1] == '0) && (vel_reg[2] == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser == REQ_MOVE)
                        state_next = S_SQ;
                    else if (s_axis_tuser == REQ_TICK && moving_reg && !pend_reg)
                        state_next = S_TICK;
                    else
                        state_next = S_DONE;
                end
            end
            S_SQ:
            begin
                if (cnt_reg == CNT_W'(CB) && ax_reg == 2'd2)
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    if (root_next == '0 || speed_reg == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(SPEED_W))
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(ACC_W - 1))
                    state_next = (ax_reg == 2'd2) ? S_DONE : S_MUL;
            end
            S_TICK:
            begin
                if (ax_reg == 2'd2)
                    state_next = S_TEND;
            end
            S_TEND:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        npos_next   = npos_reg;
        vel_next    = vel_reg;
        moving_next = moving_reg;
        pend_next   = pend_reg;
        arr_next    = arr_reg;
        speed_next  = speed_reg;
        t_next      = t_reg;
        ax_next     = ax_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    arr_next = 1'b0;
                    ax_next  = 2'd0;
                    cnt_next = '0;
                    acc_next = '0;
                    case (s_axis_tuser)
                        REQ_MOVE:
                        begin
                            tgt_next   = cin;
                            speed_next = s_axis_tdata[127:96];
                        end
                        REQ_TICK:
                        begin
                            t_next = s_axis_tdata[147:128];
                            if (moving_reg && pend_reg)
                            begin
                                pend_next   = 1'b0;
                                moving_next = 1'b0;
                            end
                        end
                        REQ_SET:
                        begin
                            pos_next  = cin;
                            pend_next = 1'b1;
                        end
                        default: moving_next = 1'b0;
                    endcase
                end
            end
            S_SQ:
            begin
                // count 0 loads the operands, then one shift-add per cycle
                if (cnt_reg == '0)
                begin
                    mcand_next  = ACC_W'(m_ax);
                    mplier_next = MPL_W'(m_ax);
                end
                else
                begin
                    if (mplier_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
                if (cnt_reg == CNT_W'(CB))
                begin
                    cnt_next = '0;
                    ax_next  = ax_reg + 2'd1;
                    rem_next  = '0;
                    root_next = '0;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                acc_next = acc_reg << 2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    cnt_next = '0;
                    ax_next  = 2'd0;
                    acc_next = '0;
                    if (root_next == '0 || speed_reg == '0)
                    begin
                        vel_next[0] = '0;
                        vel_next[1] = '0;
                        vel_next[2] = '0;
                        moving_next = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(m_ax);
                    mplier_next = MPL_W'(speed_reg);
                end
                else
                begin
                    if (mplier_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
                if (cnt_reg == CNT_W'(SPEED_W))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DIV:
            begin
                if (qbit)
                    rem_next = (RW+3)'(drem_sh - {1'b0, root_reg});
                else
                    rem_next = (RW+3)'(drem_sh);
                acc_next = {acc_reg[ACC_W-2:0], qbit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    cnt_next = '0;
                    ax_next  = ax_reg + 2'd1;
                end
            end
            S_TICK:
            begin
                npos_next[ax_reg] = pos_reg[ax_reg] + step_cb;
                if (CMP_W'(m_ax) <= CMP_W'(s_ax))
                    vel_next[ax_reg] = '0;
                ax_next = ax_reg + 2'd1;
            end
            S_TEND:
            begin
                if (vel_zero)
                begin
                    pos_next    = tgt_reg;
                    moving_next = 1'b0;
                    arr_next    = 1'b1;
                end
                else
                    pos_next = npos_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {6'd0, arr_reg, moving_reg,
                                   32'($signed(pos_reg[2])),
                                   32'($signed(pos_reg[1])),
                                   32'($signed(pos_reg[0]))};
                end
            end
            default: ;
        endcase

        // a divide result lands on the last divide cycle
        if (state_reg == S_DIV && cnt_reg == CNT_W'(ACC_W - 1))
        begin
            vel_next[ax_reg] = vsat;
            if (ax_reg == 2'd2)
                moving_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                npos_reg[i] <= '0;
            end
            moving_reg <= 1'b0;
            pend_reg   <= 1'b0;
            arr_reg    <= 1'b0;
            ax_reg     <= 2'd0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            vel_reg    <= vel_next;
            npos_reg   <= npos_next;
            moving_reg <= moving_next;
            pend_reg   <= pend_next;
            arr_reg    <= arr_next;
            ax_reg     <= ax_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg  <= speed_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        odata_reg  <= odata_next;
    end

endmodule

`default_nettype wire
